### sv/rpm_pkg.sv
`timescale 1ns / 1ps
// rpm_pkg: sizes, table entry types, FSM states and the open-bus helper
// for the ROM page mapper. No dependencies.
package rpm_pkg;

   localparam int PAGE_BITS     = 14;
   localparam int FRAME_COUNT   = 256;
   localparam int VIRTUAL_PAGES = 2048;

   localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int VPAGE_W = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;

   // clearing sweep covers whichever table is deeper
   localparam int CLR_COUNT = (VIRTUAL_PAGES > FRAME_COUNT) ? VIRTUAL_PAGES : FRAME_COUNT;
   localparam int CLR_W     = $clog2(CLR_COUNT);

   // fixed result field widths
   localparam int ADDR_W       = 32;
   localparam int SIZE_W       = 2;
   localparam int ROM_SIZE_W   = 26;
   localparam int PAGE_FIELD_W = 11;
   localparam int FADDR_W      = 22;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   typedef struct packed {
      logic               valid;
      logic [VPAGE_W-1:0] page;
   } frame_entry_type;

   typedef struct packed {
      logic               en;
      logic [VPAGE_W-1:0] page_addr;
      logic [FRAME_W-1:0] frame_addr;
   } tbl_rd_type;

   typedef struct packed {
      logic               en;
      logic [VPAGE_W-1:0] addr;
      page_entry_type     data;
   } page_wr_type;

   typedef struct packed {
      logic               en;
      logic [FRAME_W-1:0] addr;
      frame_entry_type    data;
   } frame_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVICT
   } state_type;

   // address-derived value driven on reads past the end of the image
   function automatic logic [ADDR_W-1:0] open_bus(input logic [ADDR_W-1:0] a,
                                                  input logic [SIZE_W-1:0] sz);
      logic [ADDR_W-1:0] a2;
      logic [ADDR_W-1:0] res;
      a2 = a + 32'd2;
      unique case (sz)
         SIZE_BYTE: begin
            res = {24'd0, a[8:1]};
         end
         SIZE_HALF: begin
            res = {16'd0, a[16:1]};
         end
         default: begin
            res = {a[16:1], a2[16:1]};
         end
      endcase
      return res;
   endfunction

endpackage

### sv/rpm_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the ROM page mapper.
// Depend on rpm_pkg for field widths.
interface rpm_req_if;
   logic                            valid;
   logic                            ready;
   logic [rpm_pkg::ADDR_W-1:0]      address;
   logic [rpm_pkg::SIZE_W-1:0]      access_size;

   modport source(output valid, output address, output access_size, input ready);
   modport sink(input valid, input address, input access_size, output ready);
endinterface

interface rpm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             out_of_range;
   logic [rpm_pkg::ADDR_W-1:0]       open_bus_value;
   logic                             fill_needed;
   logic [rpm_pkg::PAGE_FIELD_W-1:0] fill_page;
   logic [rpm_pkg::FADDR_W-1:0]      frame_address;
   logic                             evicted_valid;
   logic [rpm_pkg::PAGE_FIELD_W-1:0] evicted_page;

   modport source(output valid, output out_of_range, output open_bus_value,
                  output fill_needed, output fill_page, output frame_address,
                  output evicted_valid, output evicted_page, input ready);
   modport sink(input valid, input out_of_range, input open_bus_value,
                input fill_needed, input fill_page, input frame_address,
                input evicted_valid, input evicted_page, output ready);
endinterface

### sv/rom_page_mapper_round_robin.sv
`timescale 1ns / 1ps
// rom_page_mapper_round_robin: top level of the demand-paged ROM mapper.
// Depends on rpm_pkg, rpm_req_if / rpm_rsp_if and rpm_tables.
//
// Usage
//  - req_ch carries one read transaction: byte address and access size
//    (0 = byte, 1 = halfword, 2 or 3 = word). rsp_ch returns exactly one
//    transaction per request, in order.
//  - csr_we / csr_wdata load rom_size; write it only while the block is idle.
//  - Reads at or past rom_size (or past the last virtual page) answer with
//    the open-bus value and leave the mapping untouched.
//  - Otherwise the 16 KiB page is looked up. A miss takes the next frame in
//    round-robin order (frame 0 is never reused), reports fill_needed and
//    fill_page, and any page that held that frame in evicted_page.
// Sequencing
//  - Each transaction is one read of both mapping memories, then a
//    write-back; the lookup result is then registered in the output
//    register. A hit, a free-frame fill or an out-of-range read passes
//    through idle and lookup; a fill that evicts a page adds an eviction
//    state that invalidates the old page through the single write port.
//  - After reset a clearing sweep visits all 2048 page entries (one page
//    entry per cycle, frame entries alongside); req_ch.ready stays low
//    until it ends. Page 0 then sits in frame 0.
//  - The result waits in an output register while rsp_ch.ready is low; the
//    next request is still accepted, its lookup then holds until the
//    register frees.
module rom_page_mapper_round_robin (
   input  logic                            clock,
   input  logic                            reset,
   rpm_req_if.sink                         req_ch,
   rpm_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [rpm_pkg::ROM_SIZE_W-1:0]  csr_wdata
);

   rpm_pkg::state_type state_ff, state_in;

   logic [rpm_pkg::ROM_SIZE_W-1:0] rom_size_ff;
   logic [rpm_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [rpm_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic                           oor_ff, oor_in;
   logic [rpm_pkg::FRAME_W-1:0]    ptr_ff, ptr_in;
   logic [rpm_pkg::VPAGE_W-1:0]    evict_page_ff, evict_page_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_oor_ff, rsp_oor_in;
   logic [rpm_pkg::ADDR_W-1:0]       rsp_obus_ff, rsp_obus_in;
   logic                             rsp_fill_ff, rsp_fill_in;
   logic [rpm_pkg::PAGE_FIELD_W-1:0] rsp_fpage_ff, rsp_fpage_in;
   logic [rpm_pkg::FADDR_W-1:0]      rsp_faddr_ff, rsp_faddr_in;
   logic                             rsp_ev_ff, rsp_ev_in;
   logic [rpm_pkg::PAGE_FIELD_W-1:0] rsp_evpage_ff, rsp_evpage_in;

   rpm_pkg::tbl_rd_type      tbl_rd;
   rpm_pkg::page_wr_type     page_wr;
   rpm_pkg::frame_wr_type    frame_wr;
   rpm_pkg::page_entry_type  page_rd;
   rpm_pkg::frame_entry_type frame_rd;
   logic                     clr_busy;

   logic                        req_acc;
   logic                        slot_free;
   logic                        rsp_load;
   logic                        hit;
   logic                        evicting;
   logic [rpm_pkg::FRAME_W-1:0] next_frame;
   logic [rpm_pkg::FRAME_W-1:0] use_frame;
   logic [rpm_pkg::VPAGE_W-1:0] cur_page;
   logic [rpm_pkg::VPAGE_W-1:0] in_page;
   logic                        in_oor;

   rpm_tables u_tables (
      .clock    (clock),
      .reset    (reset),
      .rd       (tbl_rd),
      .page_wr  (page_wr),
      .frame_wr (frame_wr),
      .page_rd  (page_rd),
      .frame_rd (frame_rd),
      .clr_busy (clr_busy)
   );

   // round robin: step forward, wrap past the last frame to frame 1
   assign next_frame = (ptr_ff == rpm_pkg::FRAME_W'(rpm_pkg::FRAME_COUNT - 1))
                       ? rpm_pkg::FRAME_W'(1) : ptr_ff + 1'b1;

   assign in_page  = rpm_pkg::VPAGE_W'(req_ch.address >> rpm_pkg::PAGE_BITS);
   assign in_oor   = (req_ch.address >= 32'(rom_size_ff))
                  || ((req_ch.address >> rpm_pkg::PAGE_BITS) >= 32'(rpm_pkg::VIRTUAL_PAGES));
   assign cur_page = rpm_pkg::VPAGE_W'(addr_ff >> rpm_pkg::PAGE_BITS);

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign hit       = page_rd.valid;
   assign evicting  = !oor_ff && !hit && frame_rd.valid;
   assign use_frame = hit ? page_rd.frame : next_frame;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpm_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = rpm_pkg::ST_LOOK;
            end
         end
         rpm_pkg::ST_LOOK: begin
            if (slot_free) begin
               state_in = evicting ? rpm_pkg::ST_EVICT : rpm_pkg::ST_IDLE;
            end
         end
         rpm_pkg::ST_EVICT: begin
            state_in = rpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = rpm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine: table accesses and datapath loads
   always_comb begin
      req_ch.ready  = 1'b0;
      tbl_rd        = '0;
      page_wr       = '0;
      frame_wr      = '0;
      rsp_load      = 1'b0;
      ptr_in        = ptr_ff;
      evict_page_in = evict_page_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      oor_in        = oor_ff;
      unique case (state_ff)
         rpm_pkg::ST_IDLE: begin
            req_ch.ready      = !clr_busy;
            tbl_rd.en         = req_acc;
            tbl_rd.page_addr  = in_page;
            tbl_rd.frame_addr = next_frame;
            if (req_acc) begin
               addr_in = req_ch.address;
               size_in = req_ch.access_size;
               oor_in  = in_oor;
            end
         end
         rpm_pkg::ST_LOOK: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (!oor_ff && !hit) begin
                  page_wr.en          = 1'b1;
                  page_wr.addr        = cur_page;
                  page_wr.data.valid  = 1'b1;
                  page_wr.data.frame  = next_frame;
                  frame_wr.en         = 1'b1;
                  frame_wr.addr       = next_frame;
                  frame_wr.data.valid = 1'b1;
                  frame_wr.data.page  = cur_page;
                  ptr_in              = next_frame;
                  evict_page_in       = frame_rd.page;
               end
            end
         end
         rpm_pkg::ST_EVICT: begin
            page_wr.en   = 1'b1;
            page_wr.addr = evict_page_ff;
            page_wr.data = '0;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // result fields
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_oor_in    = rsp_oor_ff;
      rsp_obus_in   = rsp_obus_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_fpage_in  = rsp_fpage_ff;
      rsp_faddr_in  = rsp_faddr_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evpage_in = rsp_evpage_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (oor_ff) begin
            rsp_oor_in    = 1'b1;
            rsp_obus_in   = rpm_pkg::open_bus(addr_ff, size_ff);
            rsp_fill_in   = 1'b0;
            rsp_fpage_in  = '0;
            rsp_faddr_in  = '0;
            rsp_ev_in     = 1'b0;
            rsp_evpage_in = '0;
         end else begin
            rsp_oor_in    = 1'b0;
            rsp_obus_in   = '0;
            rsp_fill_in   = !hit;
            rsp_fpage_in  = hit ? '0 : rpm_pkg::PAGE_FIELD_W'(cur_page);
            rsp_faddr_in  = rpm_pkg::FADDR_W'({use_frame, addr_ff[rpm_pkg::PAGE_BITS-1:0]});
            rsp_ev_in     = evicting;
            rsp_evpage_in = evicting ? rpm_pkg::PAGE_FIELD_W'(frame_rd.page) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpm_pkg::ST_IDLE;
         ptr_ff       <= '0;
         rom_size_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            rom_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      oor_ff        <= oor_in;
      evict_page_ff <= evict_page_in;
      rsp_oor_ff    <= rsp_oor_in;
      rsp_obus_ff   <= rsp_obus_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_fpage_ff  <= rsp_fpage_in;
      rsp_faddr_ff  <= rsp_faddr_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evpage_ff <= rsp_evpage_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_of_range   = rsp_oor_ff;
   assign rsp_ch.open_bus_value = rsp_obus_ff;
   assign rsp_ch.fill_needed    = rsp_fill_ff;
   assign rsp_ch.fill_page      = rsp_fpage_ff;
   assign rsp_ch.frame_address  = rsp_faddr_ff;
   assign rsp_ch.evicted_valid  = rsp_ev_ff;
   assign rsp_ch.evicted_page   = rsp_evpage_ff;

   // an accepted transaction always goes to the lookup next
   a_acc_to_look: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == rpm_pkg::ST_LOOK)
      else $error("accepted transaction did not enter lookup");

   // once the pointer has left frame 0 it never returns there
   a_ptr_skips_zero: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != '0 |=> ptr_ff != '0)
      else $error("round-robin pointer landed on frame 0");

   // the sweep owns the write ports; the FSM must not write meanwhile
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !page_wr.en && !frame_wr.en)
      else $error("table write during clearing sweep");

   // an eviction is only ever reported as part of a fill
   a_evict_with_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ev_ff |-> rsp_fill_ff && !rsp_oor_ff)
      else $error("eviction reported without a fill");

   // eviction cycle always follows a lookup that found an owner
   a_evict_after_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == rpm_pkg::ST_EVICT |-> $past(state_ff) == rpm_pkg::ST_LOOK)
      else $error("invalidate cycle without a preceding lookup");

endmodule

### sv/rpm_tables.sv
`timescale 1ns / 1ps
// rpm_tables: page-to-frame and frame-to-owner mapping memories, with the
// post-reset clearing sweep. Depends on rpm_pkg.
module rpm_tables (
   input  logic                     clock,
   input  logic                     reset,
   input  rpm_pkg::tbl_rd_type      rd,
   input  rpm_pkg::page_wr_type     page_wr,
   input  rpm_pkg::frame_wr_type    frame_wr,
   output rpm_pkg::page_entry_type  page_rd,
   output rpm_pkg::frame_entry_type frame_rd,
   output logic                     clr_busy
);

   rpm_pkg::page_entry_type  page_mem  [rpm_pkg::VIRTUAL_PAGES];
   rpm_pkg::frame_entry_type frame_mem [rpm_pkg::FRAME_COUNT];

   logic [rpm_pkg::CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                      clr_busy_ff, clr_busy_in;
   rpm_pkg::page_entry_type   page_rd_ff;
   rpm_pkg::frame_entry_type  frame_rd_ff;
   rpm_pkg::page_wr_type      pw;
   rpm_pkg::frame_wr_type     fw;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == rpm_pkg::CLR_W'(rpm_pkg::CLR_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // sweep: entry 0 of each table holds page 0 in frame 0, the rest invalid
   always_comb begin
      if (clr_busy_ff) begin
         pw.en         = (32'(clr_cnt_ff) < 32'(rpm_pkg::VIRTUAL_PAGES));
         pw.addr       = rpm_pkg::VPAGE_W'(clr_cnt_ff);
         pw.data.valid = (clr_cnt_ff == '0);
         pw.data.frame = '0;
         fw.en         = (32'(clr_cnt_ff) < 32'(rpm_pkg::FRAME_COUNT));
         fw.addr       = rpm_pkg::FRAME_W'(clr_cnt_ff);
         fw.data.valid = (clr_cnt_ff == '0);
         fw.data.page  = '0;
      end else begin
         pw = page_wr;
         fw = frame_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (pw.en) begin
         page_mem[pw.addr] <= pw.data;
      end
      if (rd.en) begin
         page_rd_ff <= page_mem[rd.page_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fw.en) begin
         frame_mem[fw.addr] <= fw.data;
      end
      if (rd.en) begin
         frame_rd_ff <= frame_mem[rd.frame_addr];
      end
   end

   assign page_rd  = page_rd_ff;
   assign frame_rd = frame_rd_ff;
   assign clr_busy = clr_busy_ff;

endmodule
